/* hdl/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the max pool checker.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check on every rising edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// check on every rising edge, reset included
`define ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

/* hdl/mp1d_pkg.sv */
// ---------------------------------------------------------------------------
// mp1d_pkg
// Shared constants, register codes and control types of the max pool unit.
// ---------------------------------------------------------------------------
package mp1d_pkg;

  localparam int CHANNELS     = 64;
  localparam int MAX_POOL     = 16;
  localparam int SAMPLE_WIDTH = 16;

  localparam int POOL_W     = 5;
  localparam int NCH_W      = 7;
  localparam int WIN_W      = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;

  localparam int POOL_RESET = 2;
  localparam int NCH_RESET  = 64;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POOL_LENGTH  = 2'd0,
    CFG_NUM_CHANNELS = 2'd1
  } cfg_reg_e;

  typedef struct packed {
    logic first_row;
    logic last_row;
  } ctl_t;

endpackage

/* hdl/mp1d_ram.sv */
// ---------------------------------------------------------------------------
// mp1d_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
module mp1d_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/mp1d_ctrl.sv */
// ---------------------------------------------------------------------------
// mp1d_ctrl
// Configuration registers and the channel, row and window position counters.
// ---------------------------------------------------------------------------
module mp1d_ctrl #(
  parameter int CHANNELS = mp1d_pkg::CHANNELS,
  parameter int MAX_POOL = mp1d_pkg::MAX_POOL,
  localparam int CH_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1,
  localparam int ROW_W   = (MAX_POOL > 1) ? $clog2(MAX_POOL) : 1
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  input  logic [mp1d_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [mp1d_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                              in_fire_i,
  input  logic                              last_of_tensor_i,
  output logic [CH_W-1:0]                   ch_o,
  output mp1d_pkg::ctl_t                    ctl_o,
  output logic [mp1d_pkg::WIN_W-1:0]        win_o
);

  logic [mp1d_pkg::POOL_W-1:0] pool_q, pool_d;
  logic [mp1d_pkg::NCH_W-1:0]  nch_q, nch_d;
  logic [CH_W-1:0]             pos_q, pos_d;
  logic [ROW_W-1:0]            row_q, row_d;
  logic [mp1d_pkg::WIN_W-1:0]  win_q, win_d;

  logic [31:0]      plen_eff, nch_eff;
  logic [ROW_W-1:0] plen_m1;
  logic [CH_W-1:0]  nch_m1;
  logic [CH_W-1:0]  ch;
  logic             last_row;

  always_comb begin
    pool_d = pool_q;
    nch_d  = nch_q;
    if (cfg_valid_i) begin
      unique case (mp1d_pkg::cfg_reg_e'(cfg_index_i))
        mp1d_pkg::CFG_POOL_LENGTH:  pool_d = cfg_data_i[mp1d_pkg::POOL_W-1:0];
        mp1d_pkg::CFG_NUM_CHANNELS: nch_d  = cfg_data_i[mp1d_pkg::NCH_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (pool_q == '0) begin
      plen_eff = 32'd1;
    end else if (32'(pool_q) > 32'(MAX_POOL)) begin
      plen_eff = 32'(MAX_POOL);
    end else begin
      plen_eff = 32'(pool_q);
    end
    if (nch_q == '0) begin
      nch_eff = 32'd1;
    end else if (32'(nch_q) > 32'(CHANNELS)) begin
      nch_eff = 32'(CHANNELS);
    end else begin
      nch_eff = 32'(nch_q);
    end
  end

  always_comb begin
    logic [31:0] plen_dec, nch_dec;
    plen_dec = plen_eff - 32'd1;
    nch_dec  = nch_eff - 32'd1;
    plen_m1  = plen_dec[ROW_W-1:0];
    nch_m1   = nch_dec[CH_W-1:0];
  end

  assign ch       = (pos_q > nch_m1) ? nch_m1 : pos_q;
  assign last_row = (row_q >= plen_m1);

  always_comb begin
    pos_d = pos_q;
    row_d = row_q;
    win_d = win_q;
    if (in_fire_i) begin
      if (ch == nch_m1) begin
        pos_d = '0;
        if (last_row) begin
          row_d = '0;
          win_d = win_q + 1'b1;
        end else begin
          row_d = row_q + 1'b1;
        end
      end else begin
        pos_d = ch + 1'b1;
      end
      if (last_of_tensor_i) begin
        pos_d = '0;
        row_d = '0;
        win_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_q <= mp1d_pkg::POOL_W'(mp1d_pkg::POOL_RESET);
      nch_q  <= mp1d_pkg::NCH_W'(mp1d_pkg::NCH_RESET);
      pos_q  <= '0;
      row_q  <= '0;
      win_q  <= '0;
    end else begin
      pool_q <= pool_d;
      nch_q  <= nch_d;
      pos_q  <= pos_d;
      row_q  <= row_d;
      win_q  <= win_d;
    end
  end

  assign ch_o            = ch;
  assign ctl_o.first_row = (row_q == '0);
  assign ctl_o.last_row  = last_row;
  assign win_o           = win_q;

endmodule

/* hdl/mp1d_merge.sv */
// ---------------------------------------------------------------------------
// mp1d_merge
// Read-modify-write stage: max update with bypass, write-back, result register.
// ---------------------------------------------------------------------------
module mp1d_merge #(
  parameter int CHANNELS     = mp1d_pkg::CHANNELS,
  parameter int SAMPLE_WIDTH = mp1d_pkg::SAMPLE_WIDTH,
  localparam int CH_W        = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_fire_i,
  input  logic [CH_W-1:0]                   ch_i,
  input  mp1d_pkg::ctl_t                    ctl_i,
  input  logic [SAMPLE_WIDTH-1:0]           sample_i,
  input  logic [mp1d_pkg::WIN_W-1:0]        win_i,
  output logic                              free_o,
  input  logic [SAMPLE_WIDTH-1:0]           rd_data_i,
  output logic                              wr_en_o,
  output logic [CH_W-1:0]                   wr_addr_o,
  output logic [SAMPLE_WIDTH-1:0]           wr_data_o,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [SAMPLE_WIDTH-1:0]           max_value_o,
  output logic [CH_W-1:0]                   channel_o,
  output logic [mp1d_pkg::WIN_W-1:0]        window_index_o
);

  logic                       s1_valid_q, s1_valid_d;
  logic [CH_W-1:0]            s1_ch_q;
  mp1d_pkg::ctl_t             s1_ctl_q;
  logic [SAMPLE_WIDTH-1:0]    s1_sample_q;
  logic [mp1d_pkg::WIN_W-1:0] s1_win_q;
  logic                       byp_hit_q;
  logic [SAMPLE_WIDTH-1:0]    byp_data_q;

  logic                       out_valid_q, out_valid_d;
  logic [SAMPLE_WIDTH-1:0]    max_q;
  logic [CH_W-1:0]            chan_q;
  logic [mp1d_pkg::WIN_W-1:0] widx_q;

  logic                       s1_adv;
  logic [SAMPLE_WIDTH-1:0]    old_max;
  logic [SAMPLE_WIDTH-1:0]    new_max;

  assign s1_adv = s1_valid_q && (!s1_ctl_q.last_row || !out_valid_q || out_ready_i);
  assign free_o = !s1_valid_q || s1_adv;

  assign old_max = byp_hit_q ? byp_data_q : rd_data_i;
  assign new_max = (s1_ctl_q.first_row || ($signed(old_max) < $signed(s1_sample_q)))
                   ? s1_sample_q : old_max;

  assign wr_en_o   = s1_adv;
  assign wr_addr_o = s1_ch_q;
  assign wr_data_o = new_max;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_fire_i) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (s1_adv && s1_ctl_q.last_row) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire_i) begin
      s1_ch_q     <= ch_i;
      s1_ctl_q    <= ctl_i;
      s1_sample_q <= sample_i;
      s1_win_q    <= win_i;
      byp_hit_q   <= s1_adv && (s1_ch_q == ch_i);
      byp_data_q  <= new_max;
    end
    if (s1_adv && s1_ctl_q.last_row) begin
      max_q  <= new_max;
      chan_q <= s1_ch_q;
      widx_q <= s1_win_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign max_value_o    = max_q;
  assign channel_o      = chan_q;
  assign window_index_o = widx_q;

endmodule

/* hdl/max_pool_1d_unit.sv */
// ---------------------------------------------------------------------------
// max_pool_1d_unit
// Streaming non-overlapping 1-D max pooling with per-channel maxima in RAM.
// ---------------------------------------------------------------------------
//  channel | signals                                        | dir
//  in      | in_valid_i/in_ready_o, sample_i, last_of_tensor_i | sink
//  out     | out_valid_o/out_ready_i, max_value_o, channel_o,  | source
//          | window_index_o                                  |
//  cfg     | cfg_valid_i/cfg_ready_o, cfg_index_i, cfg_data_i | sink
//
//  One input beat per cycle sustained unless a held result stalls input; the single-port-pair RAM sets the rate.
//  A window result passes the staging register, then the result register behind
//  out_valid_o, once the closing input beat is accepted.
//  Reset clears counters and valid flags, sets register defaults; RAM contents need no clearing pass.
//  A held result stalls input only while the staged item also closes a window.
//  cfg_ready_o is always high.
// ---------------------------------------------------------------------------
module max_pool_1d_unit #(
  parameter int CHANNELS     = mp1d_pkg::CHANNELS,
  parameter int MAX_POOL     = mp1d_pkg::MAX_POOL,
  parameter int SAMPLE_WIDTH = mp1d_pkg::SAMPLE_WIDTH,
  localparam int CH_W        = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [SAMPLE_WIDTH-1:0]           sample_i,
  input  logic                              last_of_tensor_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [SAMPLE_WIDTH-1:0]           max_value_o,
  output logic [CH_W-1:0]                   channel_o,
  output logic [mp1d_pkg::WIN_W-1:0]        window_index_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [mp1d_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [mp1d_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  logic                       in_fire;
  logic [CH_W-1:0]            ch;
  mp1d_pkg::ctl_t             ctl;
  logic [mp1d_pkg::WIN_W-1:0] win;
  logic [SAMPLE_WIDTH-1:0]    rd_data;
  logic                       wr_en;
  logic [CH_W-1:0]            wr_addr;
  logic [SAMPLE_WIDTH-1:0]    wr_data;

  assign in_fire     = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  mp1d_ctrl #(
    .CHANNELS (CHANNELS),
    .MAX_POOL (MAX_POOL)
  ) u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_fire_i        (in_fire),
    .last_of_tensor_i (last_of_tensor_i),
    .ch_o             (ch),
    .ctl_o            (ctl),
    .win_o            (win)
  );

  mp1d_ram #(
    .WIDTH (SAMPLE_WIDTH),
    .DEPTH (CHANNELS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (wr_data),
    .re_i    (in_fire),
    .raddr_i (ch),
    .rdata_o (rd_data)
  );

  mp1d_merge #(
    .CHANNELS     (CHANNELS),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_merge (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_fire_i      (in_fire),
    .ch_i           (ch),
    .ctl_i          (ctl),
    .sample_i       (sample_i),
    .win_i          (win),
    .free_o         (in_ready_o),
    .rd_data_i      (rd_data),
    .wr_en_o        (wr_en),
    .wr_addr_o      (wr_addr),
    .wr_data_o      (wr_data),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .max_value_o    (max_value_o),
    .channel_o      (channel_o),
    .window_index_o (window_index_o)
  );

endmodule

/* hdl/mp1d_checker.sv */
// ---------------------------------------------------------------------------
// mp1d_checker
// Port-level checks of the max pool unit, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module mp1d_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_ready_o,
  input logic out_valid_o,
  input logic out_ready_i,
  input logic cfg_ready_o
);

  `ASSERT_CLK(out_hold_a, clk_i, rst_ni, out_valid_o && !out_ready_i |=> out_valid_o)
  `ASSERT_ALWAYS(out_reset_a, clk_i, !rst_ni |-> !out_valid_o)
  `ASSERT_CLK(in_ready_empty_a, clk_i, rst_ni, !out_valid_o |-> in_ready_o)
  `ASSERT_CLK(in_ready_drain_a, clk_i, rst_ni, out_ready_i |-> in_ready_o)
  `ASSERT_CLK(cfg_ready_a, clk_i, rst_ni, cfg_ready_o)

endmodule

bind max_pool_1d_unit mp1d_checker u_checker (.*);

/* test/max_pool_1d_checker.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// max_pool_1d_checker
// Watches the configuration, sample and result channels of the max pool unit.
// Keeps its own copy of the registers, counters and running maxima, queues
// the window maximum that each accepted sample beat closes, and compares
// every result beat field by field with the oldest queued entry.
// ---------------------------------------------------------------------------
module max_pool_1d_checker
  import mp1d_pkg::*;
#(
  parameter int CH_W = $clog2(CHANNELS)
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  input  logic                    in_ready_i,
  input  logic [SAMPLE_WIDTH-1:0] sample_i,
  input  logic                    last_of_tensor_i,
  input  logic                    out_valid_i,
  input  logic                    out_ready_i,
  input  logic [SAMPLE_WIDTH-1:0] max_value_i,
  input  logic [CH_W-1:0]         channel_i,
  input  logic [WIN_W-1:0]        window_index_i,
  input  logic                    cfg_valid_i,
  input  logic                    cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [CFG_DATA_W-1:0]   cfg_data_i,
  output int                      fail_count_o,
  output int                      pending_o
);

  localparam int ROW_W = (MAX_POOL > 1) ? $clog2(MAX_POOL) : 1;

  typedef struct packed {
    logic [SAMPLE_WIDTH-1:0] max_value;
    logic [CH_W-1:0]         channel;
    logic [WIN_W-1:0]        window_index;
  } pooled_t;

  pooled_t                        pending_maxima[$];
  logic signed [SAMPLE_WIDTH-1:0] window_max [CHANNELS];
  logic [POOL_W-1:0]              pool_len;
  logic [NCH_W-1:0]               num_ch;
  logic [CH_W-1:0]                chan_pos;
  logic [ROW_W-1:0]               row_pos;
  logic [WIN_W-1:0]               win_cnt;

  task automatic fold_sample(input logic signed [SAMPLE_WIDTH-1:0] value,
                             input logic closes_tensor);
    int unsigned                    plen;
    int unsigned                    nch;
    int unsigned                    ch;
    logic                           last_row;
    logic signed [SAMPLE_WIDTH-1:0] run_max;
    pooled_t                        res;
    plen = (pool_len == 0) ? 1 : (pool_len > MAX_POOL) ? MAX_POOL : pool_len;
    nch  = (num_ch == 0) ? 1 : (num_ch > CHANNELS) ? CHANNELS : num_ch;
    ch   = (chan_pos >= nch) ? nch - 1 : chan_pos;
    last_row = (row_pos >= plen - 1);
    run_max  = (row_pos == 0 || value > window_max[ch]) ? value : window_max[ch];
    window_max[ch] = run_max;
    if (last_row) begin
      res.max_value    = run_max;
      res.channel      = CH_W'(ch);
      res.window_index = win_cnt;
      pending_maxima.push_back(res);
    end
    if (ch + 1 >= nch) begin
      chan_pos = '0;
      if (last_row) begin
        row_pos = '0;
        win_cnt = win_cnt + 1'b1;
      end else begin
        row_pos = row_pos + 1'b1;
      end
    end else begin
      chan_pos = CH_W'(ch + 1);
    end
    if (closes_tensor) begin
      chan_pos = '0;
      row_pos  = '0;
      win_cnt  = '0;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    pooled_t exp;
    if (!rst_ni) begin
      pool_len = POOL_W'(POOL_RESET);
      num_ch   = NCH_W'(NCH_RESET);
      chan_pos = '0;
      row_pos  = '0;
      win_cnt  = '0;
      foreach (window_max[i]) window_max[i] = '0;
      pending_maxima.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_POOL_LENGTH:  pool_len = cfg_data_i[POOL_W-1:0];
          CFG_NUM_CHANNELS: num_ch   = cfg_data_i[NCH_W-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) fold_sample(sample_i, last_of_tensor_i);
      if (out_valid_i && out_ready_i) begin
        if (pending_maxima.size() == 0) begin
          $error("result beat with none due: max_value %0d channel %0d window %0d",
                 $signed(max_value_i), channel_i, window_index_i);
          fail_count_o++;
        end else begin
          exp = pending_maxima.pop_front();
          if (max_value_i !== exp.max_value) begin
            $error("max_value: expected %0d, got %0d",
                   $signed(exp.max_value), $signed(max_value_i));
            fail_count_o++;
          end
          if (channel_i !== exp.channel) begin
            $error("channel: expected %0d, got %0d", exp.channel, channel_i);
            fail_count_o++;
          end
          if (window_index_i !== exp.window_index) begin
            $error("window_index: expected %0d, got %0d",
                   exp.window_index, window_index_i);
            fail_count_o++;
          end
        end
      end
      pending_o = pending_maxima.size();
    end
  end

endmodule

/* test/max_pool_1d_unit_test.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// max_pool_1d_unit_test
// Stimulus for the max pool unit: primes every channel, runs a short list of
// corner cases (limits of both registers, extreme samples, dropped partial
// windows, register changes inside a tensor), then random tensors under
// several pacing modes, including a long result hold-off. The checker beside
// the unit predicts and compares; this module gives the verdict.
// ---------------------------------------------------------------------------
module max_pool_1d_unit_test;
  import mp1d_pkg::*;

  localparam int CH_W           = $clog2(CHANNELS);
  localparam int SETTLE_CYCLES  = 8;
  localparam int HOLDOFF_CYCLES = 300;
  localparam int PHASES         = 12;
  localparam int PHASE_BEATS    = 75;
  localparam int CYCLE_LIMIT    = 200000;

  localparam logic [CFG_IDX_W-1:0]    CFG_UNMAPPED = 2'd3;
  localparam logic [SAMPLE_WIDTH-1:0] SAMPLE_MAX   = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic [SAMPLE_WIDTH-1:0] SAMPLE_MIN   = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

  logic                    clk_i;
  logic                    rst_ni           = 1'b1;
  logic                    in_valid_i       = 1'b0;
  logic                    in_ready_o;
  logic [SAMPLE_WIDTH-1:0] sample_i         = '0;
  logic                    last_of_tensor_i = 1'b0;
  logic                    out_valid_o;
  logic                    out_ready_i      = 1'b0;
  logic [SAMPLE_WIDTH-1:0] max_value_o;
  logic [CH_W-1:0]         channel_o;
  logic [WIN_W-1:0]        window_index_o;
  logic                    cfg_valid_i      = 1'b0;
  logic                    cfg_ready_o;
  logic [CFG_IDX_W-1:0]    cfg_index_i      = '0;
  logic [CFG_DATA_W-1:0]   cfg_data_i       = '0;

  int          fail_count;
  int          pending;
  int          cycle_count     = 0;
  int unsigned send_idle_pct   = 0;
  int unsigned ready_stall_pct = 0;
  int unsigned pool_eff        = POOL_RESET;
  int unsigned chan_eff        = NCH_RESET;
  bit          holdoff         = 1'b0;
  event        holdoff_go;

  max_pool_1d_unit u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .sample_i         (sample_i),
    .last_of_tensor_i (last_of_tensor_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .max_value_o      (max_value_o),
    .channel_o        (channel_o),
    .window_index_o   (window_index_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i)
  );

  max_pool_1d_checker #(.CH_W(CH_W)) u_check (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_i       (in_ready_o),
    .sample_i         (sample_i),
    .last_of_tensor_i (last_of_tensor_i),
    .out_valid_i      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .max_value_i      (max_value_o),
    .channel_i        (channel_o),
    .window_index_i   (window_index_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_i      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .fail_count_o     (fail_count),
    .pending_o        (pending)
  );

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  always @(posedge clk_i) begin
    out_ready_i <= rst_ni && !holdoff && ($urandom_range(99) >= ready_stall_pct);
  end

  // hold off the result channel for a fixed stretch
  initial begin
    forever begin
      @(holdoff_go);
      holdoff <= 1'b1;
      repeat (HOLDOFF_CYCLES) @(posedge clk_i);
      holdoff <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic logic [SAMPLE_WIDTH-1:0] pick_sample();
    case ($urandom_range(9))
      0:       return SAMPLE_MAX;
      1:       return SAMPLE_MIN;
      default: return SAMPLE_WIDTH'($urandom);
    endcase
  endfunction

  task automatic send_sample(input logic [SAMPLE_WIDTH-1:0] value, input logic closes);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    sample_i         <= value;
    last_of_tensor_i <= closes;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
  endtask

  // wait out every queued result plus the pipeline tail
  task automatic drain();
    in_valid_i  <= 1'b0;
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic configure(input int unsigned pool, input int unsigned nch);
    logic [CFG_DATA_W-1:0] word;
    drain();
    word = CFG_DATA_W'($urandom);
    word[POOL_W-1:0] = POOL_W'(pool);
    write_reg(CFG_POOL_LENGTH, word);
    write_reg(CFG_NUM_CHANNELS, CFG_DATA_W'(nch));
    cfg_valid_i <= 1'b0;
    pool_eff = (pool == 0) ? 1 : (pool > MAX_POOL) ? MAX_POOL : pool;
    chan_eff = (nch == 0) ? 1 : (nch > CHANNELS) ? CHANNELS : nch;
  endtask

  initial begin
    int unsigned sent;
    int unsigned n;
    int unsigned pool;
    int unsigned nch;
    logic        closes;
    rst_ni <= 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // prime every channel's maximum with one full window at the reset shape
    for (int k = 0; k < POOL_RESET * NCH_RESET; k++) begin
      send_sample(pick_sample(), k == POOL_RESET * NCH_RESET - 1);
    end

    configure(1, 1);
    send_sample(SAMPLE_MAX, 1'b0);
    send_sample(SAMPLE_MIN, 1'b0);
    send_sample(16'hFFFF, 1'b1);
    drain();
    write_reg(CFG_UNMAPPED, CFG_DATA_W'($urandom));
    configure(0, 0);
    send_sample(16'h0001, 1'b0);
    send_sample(16'h1234, 1'b1);
    configure(3, 2);
    send_sample(SAMPLE_MIN, 1'b0);
    send_sample(SAMPLE_MAX, 1'b0);
    send_sample(16'h0001, 1'b0);
    send_sample(SAMPLE_MIN, 1'b0);
    send_sample(16'hFFFF, 1'b0);
    send_sample(16'h0000, 1'b0);
    send_sample(16'h0123, 1'b0);
    send_sample(16'h4567, 1'b1);
    configure(17, 3);
    send_sample(16'h1111, 1'b0);
    send_sample(16'h2222, 1'b0);
    send_sample(16'h3333, 1'b0);
    send_sample(SAMPLE_MIN, 1'b0);
    send_sample(SAMPLE_MAX, 1'b0);
    configure(2, 2);
    send_sample(16'h0000, 1'b1);
    configure(1, 127);
    send_sample(SAMPLE_MIN, 1'b0);
    send_sample(SAMPLE_MAX, 1'b1);

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin pool = 1;  nch = $urandom_range(2, 8); end
        1: begin pool = 31; nch = 3;   end
        2: begin pool = 2;  nch = 127; end
        3: begin pool = 16; nch = 1;   end
        4: begin pool = 0;  nch = 0;   end
        default: begin
          if ($urandom_range(3) == 0) begin
            pool = $urandom_range(0, 31);
            nch  = $urandom_range(0, 20);
          end else begin
            pool = $urandom_range(1, 6);
            nch  = $urandom_range(1, 12);
          end
        end
      endcase
      configure(pool, nch);
      case (ph % 4)
        0: begin send_idle_pct = 0;  ready_stall_pct = 0;  end
        1: begin send_idle_pct = 83; ready_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  ready_stall_pct = 83; end
        default: begin send_idle_pct = 35; ready_stall_pct = 35; end
      endcase
      if (ph == 0) -> holdoff_go;
      sent = 0;
      while (sent < PHASE_BEATS) begin
        n = $urandom_range(1, 3) * pool_eff * chan_eff;
        if ($urandom_range(3) == 0) n += $urandom_range(1, pool_eff * chan_eff);
        for (int k = 0; k < n && sent < PHASE_BEATS; k++) begin
          closes = (k == n - 1) || ($urandom_range(49) == 0);
          send_sample(pick_sample(), closes);
          sent++;
        end
      end
    end

    drain();
    if (fail_count == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
